/* src/smr_pkg.sv */
// Shared types and constants of the stepper motion ramp controller.
// Used by every module of the block; depends on nothing else.
package smr_pkg;

    // Command codes carried in the opcode field.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_REL     = 2'd1;
    localparam logic [1:0] OP_ABS     = 2'd2;
    localparam logic [1:0] OP_SETPOS  = 2'd3;

    // End actions and finish events.
    localparam logic [1:0] END_NONE    = 2'd0;
    localparam logic [1:0] END_DISABLE = 2'd1;
    localparam logic [1:0] END_BRAKE   = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_W   = 1;
    localparam int         CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 1'b1;

    localparam int          EXP_BITS_DEF  = 16;
    localparam int          PERIOD_W      = 24;
    localparam int          BASE_W        = 16;
    localparam logic [15:0] BASE_RESET    = 16'd10;
    localparam logic [15:0] SETPOS_PERIOD = 16'd10;
    localparam logic [16:0] ONE_Q16       = 17'h10000;

    // Operand widths of the shared multiplier.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] amount;
        logic [15:0]        period_ms;
        logic [1:0]         end_action;
    } t_in_item;

    typedef struct packed {
        logic               step_pulse;
        logic               step_dir;
        logic               enable_event;
        logic [1:0]         finish_event;
        logic signed [31:0] cur_position;
        logic signed [31:0] remaining;
        logic               status;
    } t_out_item;

endpackage

/* src/stepper_motion_ramp_controller_unit.sv */
// Top level of the stepper motion ramp controller: command decode, motion
// state, countdown and output register. Depends on smr_pkg and smr_period.
//
//  Channel  | Signals                                  | Direction
//  ---------+------------------------------------------+----------
//  in       | i_in_valid, o_in_ready, i_in_data        | command or tick in
//  out      | o_out_valid, i_out_ready, o_out_data     | one result per item
//  cfg      | i_cfg_we, i_cfg_index, i_cfg_data        | register writes
//
// One item at a time. A tick that runs no slot, a rejected command and a
// slot that finishes a move go straight to the output register. A slot that
// steps first waits for the step period from the shared multiplier in
// smr_period, which works through the bits of the larger ramp exponent.
// A new item is taken while the previous result still waits in the output
// register; the result of the new item waits until that one is transferred.
// Reset is synchronous and clears the motion state to idle.
module stepper_motion_ramp_controller_unit #(
    parameter int EXP_BITS = smr_pkg::EXP_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  smr_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output smr_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [smr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [smr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import smr_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SLOT, S_EXPN, S_WAIT, S_EMIT} t_state;

    t_state              r_state;
    t_in_item            r_item;
    logic [15:0]         r_accel;
    logic [15:0]         r_decay;
    logic [31:0]         r_pos;
    logic [31:0]         r_sl;
    logic [31:0]         r_ml;
    logic [BASE_W-1:0]   r_base;
    logic [1:0]          r_fm;
    logic                r_running;
    logic [PERIOD_W-1:0] r_cd;
    logic signed [32:0]  r_done;
    logic                r_pulse;
    logic                r_dir;
    logic                r_en;
    logic [1:0]          r_fin;
    logic                r_status;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [32:0]         w_abs_done;
    logic [32:0]         w_arem_m1;
    logic [EXP_BITS-1:0] w_exp_done;
    logic [EXP_BITS-1:0] w_exp_rem;
    logic                w_per_done;
    logic [PERIOD_W-1:0] w_period;
    logic                w_in_xfer;

    assign w_in_xfer = i_in_valid && o_in_ready;

    // Exponents of the two ramp powers, saturated to the exponent width.
    // |rem| - 1 is ~rem for negative rem.
    assign w_abs_done = r_done[32] ? 33'(-r_done) : 33'(r_done);
    assign w_arem_m1  = r_sl[31] ? {1'b0, ~r_sl} : {1'b0, r_sl - 32'd1};
    assign w_exp_done = (|w_abs_done[32:EXP_BITS]) ? {EXP_BITS{1'b1}}
                                                   : w_abs_done[EXP_BITS-1:0];
    assign w_exp_rem  = (|w_arem_m1[32:EXP_BITS]) ? {EXP_BITS{1'b1}}
                                                  : w_arem_m1[EXP_BITS-1:0];

    smr_period #(
        .EXP_BITS (EXP_BITS)
    ) u_period (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_EXPN),
        .i_base   (r_base),
        .i_accel  (r_accel),
        .i_ratio  (r_decay),
        .i_exp_a  (w_exp_done),
        .i_exp_b  (w_exp_rem),
        .o_done   (w_per_done),
        .o_period (w_period)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accel     <= '0;
            r_decay     <= '0;
            r_pos       <= '0;
            r_sl        <= '0;
            r_ml        <= '0;
            r_base      <= BASE_RESET;
            r_fm        <= END_NONE;
            r_running   <= 1'b0;
            r_cd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACCEL: r_accel <= i_cfg_data;
                    CFG_DECAY: r_decay <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_item   <= i_in_data;
                        r_pulse  <= 1'b0;
                        r_dir    <= 1'b0;
                        r_en     <= 1'b0;
                        r_fin    <= END_NONE;
                        r_status <= 1'b0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_item.opcode)
                        OP_TICK: begin
                            if (!r_running) begin
                                r_state <= S_EMIT;
                            end else if (r_cd > PERIOD_W'(1)) begin
                                r_cd    <= r_cd - PERIOD_W'(1);
                                r_state <= S_EMIT;
                            end else begin
                                r_cd    <= '0;
                                r_state <= S_SLOT;
                            end
                        end
                        OP_SETPOS: begin
                            if (r_sl != '0) begin
                                r_status <= 1'b1;
                                r_state  <= S_EMIT;
                            end else begin
                                r_pos     <= r_item.amount;
                                r_ml      <= r_item.amount;
                                r_base    <= SETPOS_PERIOD;
                                r_fm      <= END_NONE;
                                r_running <= 1'b1;
                                r_state   <= S_SLOT;
                            end
                        end
                        default: begin
                            if (r_item.period_ms == '0) begin
                                r_status <= 1'b1;
                                r_state  <= S_EMIT;
                            end else begin
                                if (r_item.opcode == OP_ABS) begin
                                    r_sl <= r_item.amount - r_pos;
                                    r_ml <= r_item.amount - r_pos;
                                end else begin
                                    r_sl <= r_item.amount;
                                    r_ml <= r_item.amount;
                                end
                                r_base    <= r_item.period_ms;
                                r_fm      <= r_item.end_action;
                                r_running <= 1'b1;
                                r_en      <= 1'b1;
                                r_state   <= S_SLOT;
                            end
                        end
                    endcase
                end
                S_SLOT: begin
                    if (r_sl != '0) begin
                        r_done  <= $signed({r_ml[31], r_ml}) - $signed({r_sl[31], r_sl});
                        r_state <= S_EXPN;
                    end else begin
                        // An end action of three is kept but acts as none.
                        r_fin     <= (r_fm == END_DISABLE || r_fm == END_BRAKE) ? r_fm
                                                                              : END_NONE;
                        r_running <= 1'b0;
                        r_cd      <= PERIOD_W'(r_base);
                        r_state   <= S_EMIT;
                    end
                end
                S_EXPN: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_per_done) begin
                        r_cd    <= w_period;
                        r_pulse <= 1'b1;
                        r_dir   <= ~r_sl[31];
                        if (r_sl[31]) begin
                            r_sl  <= r_sl + 32'd1;
                            r_pos <= r_pos - 32'd1;
                        end else begin
                            r_sl  <= r_sl - 32'd1;
                            r_pos <= r_pos + 32'd1;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid        <= 1'b1;
                        r_out.step_pulse   <= r_pulse;
                        r_out.step_dir     <= r_dir;
                        r_out.enable_event <= r_en;
                        r_out.finish_event <= r_fin;
                        r_out.cur_position <= r_pos;
                        r_out.remaining    <= r_sl;
                        r_out.status       <= r_status;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/smr_mul.sv */
// Shared unsigned multiplier with a registered product.
// Depends on smr_pkg for the operand widths.
module smr_mul (
    input  logic                        i_clk,
    input  logic [smr_pkg::MUL_A_W-1:0] i_a,
    input  logic [smr_pkg::MUL_B_W-1:0] i_b,
    output logic [smr_pkg::MUL_P_W-1:0] o_p
);
    import smr_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* src/smr_period.sv */
// Step period sequencer: two Q1.16 powers by square and multiply, then
// base + (base * accel * sum >> 24), saturated, all on one shared multiplier.
// Depends on smr_pkg and smr_mul.
module smr_period #(
    parameter int EXP_BITS = smr_pkg::EXP_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [smr_pkg::BASE_W-1:0]   i_base,
    input  logic [15:0]                  i_accel,
    input  logic [15:0]                  i_ratio,
    input  logic [EXP_BITS-1:0]          i_exp_a,
    input  logic [EXP_BITS-1:0]          i_exp_b,
    output logic                         o_done,
    output logic [smr_pkg::PERIOD_W-1:0] o_period
);
    import smr_pkg::*;

    typedef enum logic [2:0] {P_IDLE, P_LOOP, P_BA, P_MUL2, P_FIN} t_pstate;
    typedef enum logic [1:0] {OPS_NONE, OPS_A, OPS_B, OPS_S} t_op;

    t_pstate             r_state;
    t_op                 r_op_q;
    logic [1:0]          r_ph;
    logic [15:0]         r_b;
    logic [16:0]         r_acc_a;
    logic [16:0]         r_acc_b;
    logic [EXP_BITS-1:0] r_ea;
    logic [EXP_BITS-1:0] r_eb;
    logic                r_done;
    logic [PERIOD_W-1:0] r_period;

    t_op                 w_op;
    logic [MUL_A_W-1:0]  w_a;
    logic [MUL_B_W-1:0]  w_bm;
    logic [MUL_P_W-1:0]  w_p;
    logic [15:0]         w_b_cur;
    logic                w_exp_zero;
    logic [PERIOD_W+2:0] w_sum;

    smr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_bm),
        .o_p   (w_p)
    );

    // A square issued in the previous cycle has not reached r_b yet.
    assign w_b_cur    = (r_op_q == OPS_S) ? w_p[31:16] : r_b;
    assign w_exp_zero = (r_ea == '0) && (r_eb == '0);
    assign w_sum      = (PERIOD_W+3)'(i_base) + (PERIOD_W+3)'(w_p[MUL_P_W-1:24]);

    always_comb begin
        w_op = OPS_NONE;
        w_a  = '0;
        w_bm = '0;
        unique case (r_state)
            P_LOOP: begin
                case (r_ph)
                    2'd0: begin
                        if (!w_exp_zero && r_ea[0]) begin
                            w_op = OPS_A;
                            w_a  = MUL_A_W'(r_acc_a);
                            w_bm = MUL_B_W'(w_b_cur);
                        end
                    end
                    2'd1: begin
                        if (r_eb[0]) begin
                            w_op = OPS_B;
                            w_a  = MUL_A_W'(r_acc_b);
                            w_bm = MUL_B_W'(w_b_cur);
                        end
                    end
                    2'd2: begin
                        w_op = OPS_S;
                        w_a  = MUL_A_W'(w_b_cur);
                        w_bm = MUL_B_W'(w_b_cur);
                    end
                    default: w_op = OPS_NONE;
                endcase
            end
            P_BA: begin
                w_a  = MUL_A_W'(i_base);
                w_bm = MUL_B_W'(i_accel);
            end
            P_MUL2: begin
                w_a  = w_p[MUL_A_W-1:0];
                w_bm = MUL_B_W'(r_acc_a) + MUL_B_W'(r_acc_b);
            end
            default: w_op = OPS_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_op_q  <= OPS_NONE;
            r_done  <= 1'b0;
            r_ph    <= 2'd0;
        end else begin
            r_done <= 1'b0;
            r_op_q <= w_op;
            case (r_op_q)
                OPS_A:   r_acc_a <= w_p[32:16];
                OPS_B:   r_acc_b <= w_p[32:16];
                OPS_S:   r_b     <= w_p[31:16];
                default: ;
            endcase
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_b     <= i_ratio;
                        r_acc_a <= ONE_Q16;
                        r_acc_b <= ONE_Q16;
                        r_ea    <= i_exp_a;
                        r_eb    <= i_exp_b;
                        r_ph    <= 2'd0;
                        r_state <= P_LOOP;
                    end
                end
                P_LOOP: begin
                    case (r_ph)
                        2'd0: begin
                            if (w_exp_zero) begin
                                r_state <= P_BA;
                            end else begin
                                r_ph <= 2'd1;
                            end
                        end
                        2'd1: r_ph <= 2'd2;
                        default: begin
                            r_ea <= r_ea >> 1;
                            r_eb <= r_eb >> 1;
                            r_ph <= 2'd0;
                        end
                    endcase
                end
                P_BA:   r_state <= P_MUL2;
                P_MUL2: r_state <= P_FIN;
                P_FIN: begin
                    r_period <= (|w_sum[PERIOD_W+2:PERIOD_W]) ? {PERIOD_W{1'b1}}
                                                              : w_sum[PERIOD_W-1:0];
                    r_done   <= 1'b1;
                    r_state  <= P_IDLE;
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_period = r_period;

endmodule
